[rtl/core/jrcs_pkg.sv]
// ----------------------------------------------------------------------------
// jrcs_pkg
// Shared widths and constants for the Jacobi rotation cosine/sine pipeline.
// ----------------------------------------------------------------------------
package jrcs_pkg;

  localparam int unsigned IN_W    = 32;  // Q16.16 operand width
  localparam int unsigned DIFF_W  = 33;  // exact d = a_qq - a_pp and e = 2*a_pq
  localparam int unsigned MAG_W   = 31;  // magnitudes after range reduction
  localparam int unsigned OUT_W   = 31;  // Q1.30 result width
  localparam int unsigned FRAC_W  = 30;  // fraction bits of Q1.30

  localparam logic [OUT_W-1:0] ONE_Q30 = OUT_W'(1) << FRAC_W;

endpackage

[rtl/core/jrcs_sqrt_pipe.sv]
// ----------------------------------------------------------------------------
// jrcs_sqrt_pipe
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module jrcs_sqrt_pipe #(
  parameter int unsigned RAD_W  = 64,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RAD_W-1:0]     radicand,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output logic [RAD_W/2-1:0]   root,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int unsigned RW    = RAD_W / 2;
  localparam int unsigned REM_W = RW + 2;

  logic [RAD_W-1:0]  rad_q  [RW+1];
  logic [REM_W-1:0]  rem_q  [RW+1];
  logic [RW-1:0]     root_q [RW+1];
  logic              vld_q  [RW+1];
  logic [SIDE_W-1:0] side_q [RW+1];

  assign rad_q[0]  = radicand;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign vld_q[0]  = in_valid;
  assign side_q[0] = in_side;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic             ge;

    always_comb begin
      rem_sh = {rem_q[i], rad_q[i][RAD_W-1 -: 2]};
      trial  = {2'b00, root_q[i], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
      rad_q[i+1]  <= rad_q[i] << 2;
      rem_q[i+1]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
      root_q[i+1] <= {root_q[i][RW-2:0], ge};
      side_q[i+1] <= side_q[i];
    end
  end

  assign out_valid = vld_q[RW];
  assign root      = root_q[RW];
  assign out_side  = side_q[RW];

endmodule

[rtl/core/jrcs_div_pipe.sv]
// ----------------------------------------------------------------------------
// jrcs_div_pipe
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module jrcs_div_pipe #(
  parameter int unsigned NUM_W  = 62,
  parameter int unsigned DEN_W  = 33,
  parameter int unsigned Q_W    = 31,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    quo,
  output logic [SIDE_W-1:0] out_side
);

  // The caller guarantees the quotient fits in Q_W bits, so the bits above
  // the low Q_W of the numerator already form a partial remainder below den.
  logic [DEN_W-1:0]  rem_q  [Q_W+1];
  logic [Q_W-1:0]    lo_q   [Q_W+1];
  logic [Q_W-1:0]    quo_q  [Q_W+1];
  logic [DEN_W-1:0]  den_q  [Q_W+1];
  logic              vld_q  [Q_W+1];
  logic [SIDE_W-1:0] side_q [Q_W+1];

  assign rem_q[0]  = DEN_W'(num >> Q_W);
  assign lo_q[0]   = num[Q_W-1:0];
  assign quo_q[0]  = '0;
  assign den_q[0]  = den;
  assign vld_q[0]  = in_valid;
  assign side_q[0] = in_side;

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    logic [DEN_W:0] rem_sh;
    logic           ge;

    always_comb begin
      rem_sh = {rem_q[i], lo_q[i][Q_W-1]};
      ge     = (rem_sh >= {1'b0, den_q[i]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
      rem_q[i+1]  <= ge ? DEN_W'(rem_sh - {1'b0, den_q[i]}) : DEN_W'(rem_sh);
      lo_q[i+1]   <= lo_q[i] << 1;
      quo_q[i+1]  <= {quo_q[i][Q_W-2:0], ge};
      den_q[i+1]  <= den_q[i];
      side_q[i+1] <= side_q[i];
    end
  end

  assign out_valid = vld_q[Q_W];
  assign quo       = quo_q[Q_W];
  assign out_side  = side_q[Q_W];

endmodule

[rtl/core/jacobi_rotation_cos_sin.sv]
// ----------------------------------------------------------------------------
// jacobi_rotation_cos_sin
// Cosine and sine of the Jacobi rotation that zeroes a symmetric 2x2
// block's off-diagonal entry.
// ----------------------------------------------------------------------------
// Usage: drive a_pp, a_pq, a_qq (signed Q16.16) and pulse start. An item is
// taken at every clock edge where start is high and busy is low; busy never
// rises, so one item can enter in every cycle.
// Each item yields one result, cos_value (unsigned Q1.30) and sin_value
// (signed Q1.30), shown for exactly one cycle with done high. Results leave
// in the order items came.
// The pipeline is a chain of bit-serial units: a 32-stage square
// root for sqrt(d^2+e^2), a 31-stage divider for the tangent, a 31-stage
// square root for sqrt(1+t^2) and a 31-stage divider for the cosine, plus
// eleven stages of range reduction, multiplies, rounding and output.
// The pipeline never stalls: the receiver must take every result when done
// is high. Reset clears all valid bits, so no result appears for items that
// were in flight; the data registers are not reset.
// ----------------------------------------------------------------------------
module jacobi_rotation_cos_sin
  import jrcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [IN_W-1:0]   a_pp,
  input  logic signed [IN_W-1:0]   a_pq,
  input  logic signed [IN_W-1:0]   a_qq,
  output logic                     done,
  output logic [OUT_W-1:0]         cos_value,
  output logic signed [OUT_W-1:0]  sin_value
);

  localparam int unsigned SQ1_W  = 2 * MAG_W + 2;    // radicand of first root
  localparam int unsigned R1_W   = SQ1_W / 2;
  localparam int unsigned DEN1_W = R1_W + 1;
  localparam int unsigned NUM1_W = MAG_W + FRAC_W + 1;
  localparam int unsigned SQ2_W  = 2 * OUT_W;
  localparam int unsigned NUM2_W = 2 * FRAC_W + 1;
  localparam int unsigned SIDE1_W = 2 + 2 * MAG_W;
  localparam int unsigned SIDE2_W = 2 + OUT_W;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Stage 1: exact difference, doubled off-diagonal, magnitudes.
  logic                  v1, zero1, pos1;
  logic [DIFF_W-1:0]     ad1, ae1;
  logic signed [DIFF_W-1:0] d_w, e_w;

  always_comb begin
    d_w = DIFF_W'(a_qq) - DIFF_W'(a_pp);
    e_w = {a_pq, 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    zero1 <= (a_pq == '0);
    pos1  <= (d_w > 0 && e_w > 0) || (d_w < 0 && e_w < 0);
    ad1   <= d_w[DIFF_W-1] ? DIFF_W'(-d_w) : DIFF_W'(d_w);
    ae1   <= e_w[DIFF_W-1] ? DIFF_W'(-e_w) : DIFF_W'(e_w);
  end

  // Stage 2: shift both magnitudes right until they fit in 31 bits.
  logic              v2, zero2, pos2;
  logic [MAG_W-1:0]  ad2, ae2;
  logic [DIFF_W-1:0] hi1;
  assign hi1 = ad1 | ae1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    zero2 <= zero1;
    pos2  <= pos1;
    if (hi1[DIFF_W-1]) begin
      ad2 <= MAG_W'(ad1 >> 2);
      ae2 <= MAG_W'(ae1 >> 2);
    end else if (hi1[DIFF_W-2]) begin
      ad2 <= MAG_W'(ad1 >> 1);
      ae2 <= MAG_W'(ae1 >> 1);
    end else begin
      ad2 <= MAG_W'(ad1);
      ae2 <= MAG_W'(ae1);
    end
  end

  // Stage 3: squares. Stage 4: their sum.
  logic                v3, zero3, pos3, v4, zero4, pos4;
  logic [MAG_W-1:0]    ad3, ae3, ad4, ae4;
  logic [2*MAG_W-1:0]  dsq3, esq3;
  logic [SQ1_W-1:0]    sum4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v3 <= v2;
      v4 <= v3;
    end
    zero3 <= zero2;
    pos3  <= pos2;
    ad3   <= ad2;
    ae3   <= ae2;
    dsq3  <= (2*MAG_W)'(ad2) * (2*MAG_W)'(ad2);
    esq3  <= (2*MAG_W)'(ae2) * (2*MAG_W)'(ae2);
    zero4 <= zero3;
    pos4  <= pos3;
    ad4   <= ad3;
    ae4   <= ae3;
    sum4  <= SQ1_W'(dsq3) + SQ1_W'(esq3);
  end

  // r = floor(sqrt(|d|^2 + |e|^2)).
  logic                v5;
  logic [R1_W-1:0]     r5;
  logic [SIDE1_W-1:0]  side5;

  jrcs_sqrt_pipe #(
    .RAD_W  (SQ1_W),
    .SIDE_W (SIDE1_W)
  ) u_sqrt_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .radicand  (sum4),
    .in_side   ({zero4, pos4, ad4, ae4}),
    .out_valid (v5),
    .root      (r5),
    .out_side  (side5)
  );

  // den = |d| + r, then the rounded numerator |e| * 2^30 + den/2.
  logic                v6, zero6, pos6, v7, zero7, pos7, dz7;
  logic [MAG_W-1:0]    ae6;
  logic [DEN1_W-1:0]   den6, den7;
  logic [NUM1_W-1:0]   num7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      v6 <= v5;
      v7 <= v6;
    end
    zero6 <= side5[SIDE1_W-1];
    pos6  <= side5[SIDE1_W-2];
    ae6   <= side5[MAG_W-1:0];
    den6  <= DEN1_W'(side5[2*MAG_W-1:MAG_W]) + DEN1_W'(r5);
    zero7 <= zero6;
    pos7  <= pos6;
    dz7   <= (den6 == '0);
    den7  <= den6;
    num7  <= (NUM1_W'(ae6) << FRAC_W) + NUM1_W'(den6 >> 1);
  end

  // tm = |t| in Q1.30.
  logic               v8;
  logic [OUT_W-1:0]   q8;
  logic [2:0]         side8;

  jrcs_div_pipe #(
    .NUM_W  (NUM1_W),
    .DEN_W  (DEN1_W),
    .Q_W    (OUT_W),
    .SIDE_W (3)
  ) u_div_tan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v7),
    .num       (num7),
    .den       (den7),
    .in_side   ({zero7, pos7, dz7}),
    .out_valid (v8),
    .quo       (q8),
    .out_side  (side8)
  );

  // tm^2, then 2^60 + tm^2.
  logic               v9, zero9, pos9, v10, zero10, pos10;
  logic [OUT_W-1:0]   tm9, tm10;
  logic [SQ2_W-1:0]   tsq9, rad10;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9  <= 1'b0;
      v10 <= 1'b0;
    end else begin
      v9  <= v8;
      v10 <= v9;
    end
    zero9  <= side8[2];
    pos9   <= side8[1];
    tm9    <= side8[0] ? '0 : q8;
    tsq9   <= side8[0] ? '0 : SQ2_W'(q8) * SQ2_W'(q8);
    zero10 <= zero9;
    pos10  <= pos9;
    tm10   <= tm9;
    rad10  <= (SQ2_W'(1) << (2 * FRAC_W)) + tsq9;
  end

  // sq = sqrt(1 + t^2) in Q1.30.
  logic               v11;
  logic [OUT_W-1:0]   sq11;
  logic [SIDE2_W-1:0] side11;

  jrcs_sqrt_pipe #(
    .RAD_W  (SQ2_W),
    .SIDE_W (SIDE2_W)
  ) u_sqrt_sec (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v10),
    .radicand  (rad10),
    .in_side   ({zero10, pos10, tm10}),
    .out_valid (v11),
    .root      (sq11),
    .out_side  (side11)
  );

  logic               v12;
  logic [NUM2_W-1:0]  num12;
  logic [OUT_W-1:0]   sq12;
  logic [SIDE2_W-1:0] side12;

  always_ff @(posedge clk) begin
    if (rst) begin
      v12 <= 1'b0;
    end else begin
      v12 <= v11;
    end
    num12  <= (NUM2_W'(1) << (2 * FRAC_W)) + NUM2_W'(sq11 >> 1);
    sq12   <= sq11;
    side12 <= side11;
  end

  // c = round(2^60 / sq).
  logic               v13;
  logic [OUT_W-1:0]   c13;
  logic [SIDE2_W-1:0] side13;

  jrcs_div_pipe #(
    .NUM_W  (NUM2_W),
    .DEN_W  (OUT_W),
    .Q_W    (OUT_W),
    .SIDE_W (SIDE2_W)
  ) u_div_cos (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v12),
    .num       (num12),
    .den       (sq12),
    .in_side   (side12),
    .out_valid (v13),
    .quo       (c13),
    .out_side  (side13)
  );

  // s = round(tm * c / 2^30), signed by the direction of the rotation.
  logic               v14, zero14, pos14;
  logic [OUT_W-1:0]   c14;
  logic [2*OUT_W-1:0] prod14;
  logic [2*OUT_W-1:0] rnd14;
  logic [OUT_W-1:0]   sm14;

  always_ff @(posedge clk) begin
    if (rst) begin
      v14 <= 1'b0;
    end else begin
      v14 <= v13;
    end
    zero14 <= side13[SIDE2_W-1];
    pos14  <= side13[SIDE2_W-2];
    c14    <= c13;
    prod14 <= (2*OUT_W)'(side13[OUT_W-1:0]) * (2*OUT_W)'(c13);
  end

  always_comb begin
    rnd14 = prod14 + ((2*OUT_W)'(1) << (FRAC_W - 1));
    sm14  = OUT_W'(rnd14 >> FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v14;
    end
    if (zero14) begin
      cos_value <= ONE_Q30;
      sin_value <= '0;
    end else begin
      cos_value <= c14;
      sin_value <= pos14 ? sm14 : OUT_W'(-sm14);
    end
  end

endmodule
